[hdl/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// pcd_pkg: shared types, constants and helpers of the product counter display
// Counter value types, BCD step functions and the seven-segment decode table.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int unsigned CountW = 14;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = 14'd9999;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BLANK_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIT_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_TICKS = 2'd2;

  localparam logic [3:0]  BlankTicksRst = 4'd4;
  localparam logic [3:0]  LitTicksRst   = 4'd4;
  localparam logic [15:0] AlarmTicksRst = 16'd5000;

  localparam logic [7:0] SegBlank   = 8'hFF;
  localparam logic [3:0] EnablesOff = 4'hF;

  typedef logic [3:0][3:0] bcd_t;  // [3] thousands .. [0] units

  typedef struct packed {
    bcd_t              bcd;
    logic [CountW-1:0] bin;
  } count_t;

  typedef struct packed {
    logic beam_blocked;
    logic up_n;
    logic down_n;
    logic clear_n;
  } pins_t;

  typedef struct packed {
    logic [3:0] blank_ticks;
    logic [3:0] lit_ticks;
  } scan_cfg_t;

  // active-low segment pattern of one decimal digit
  function automatic logic [7:0] seg_decode(logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

  // count up, wrapping the top value to zero
  function automatic count_t cnt_inc(count_t c);
    count_t r;
    logic   carry;
    r     = c;
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry) begin
        if (r.bcd[i] == 4'd9) begin
          r.bcd[i] = 4'd0;
        end else begin
          r.bcd[i] = r.bcd[i] + 4'd1;
          carry    = 1'b0;
        end
      end
    end
    r.bin = (c.bin == CountMax) ? '0 : c.bin + 14'd1;
    return r;
  endfunction

  // count down, holding at zero
  function automatic count_t cnt_dec(count_t c);
    count_t r;
    logic   borrow;
    r      = c;
    borrow = (c.bin != '0);
    for (int i = 0; i < 4; i++) begin
      if (borrow) begin
        if (r.bcd[i] == 4'd0) begin
          r.bcd[i] = 4'd9;
        end else begin
          r.bcd[i] = r.bcd[i] - 4'd1;
          borrow   = 1'b0;
        end
      end
    end
    if (c.bin != '0) begin
      r.bin = c.bin - 14'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/pcd_if.sv]
// ----------------------------------------------------------------------------
// pcd_if: valid/ready channels of the product counter display
// Tick channel carrying sampled pin levels, and result channel to the panel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcd_tick_if;
  logic valid;
  logic ready;
  logic beam_blocked;
  logic up_n;
  logic down_n;
  logic clear_n;

  modport source (output valid, output beam_blocked, output up_n, output down_n,
                  output clear_n, input ready);
  modport sink   (input valid, input beam_blocked, input up_n, input down_n,
                  input clear_n, output ready);
endinterface

interface pcd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  segments_n;
  logic [3:0]  digit_enables_n;
  logic        alarm_active;
  logic [13:0] count_value;

  modport source (output valid, output segments_n, output digit_enables_n,
                  output alarm_active, output count_value, input ready);
  modport sink   (input valid, input segments_n, input digit_enables_n,
                  input alarm_active, input count_value, output ready);
endinterface

`default_nettype wire

[hdl/pcd_scan.sv]
// ----------------------------------------------------------------------------
// pcd_scan: four-digit display multiplexer
// Blanks, then lights one digit at a time, thousands first.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_scan
  import pcd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire scan_cfg_t cfg_i,
  input  wire bcd_t      shown_i,
  output logic [7:0]     segments_o,
  output logic [3:0]     enables_o
);

  logic [4:0] phase_q, phase_d, phase_inc, lit_end;
  logic [1:0] pos_q, pos_d;
  logic [7:0] seg_q, seg_d;
  logic [3:0] en_q, en_d;

  always_comb begin
    phase_inc = phase_q + 5'd1;
    lit_end   = {1'b0, cfg_i.blank_ticks} + {1'b0, cfg_i.lit_ticks};
    phase_d   = phase_inc;
    pos_d     = pos_q;
    seg_d     = seg_q;
    en_d      = en_q;
    if (phase_inc == {1'b0, cfg_i.blank_ticks}) begin
      // light the next digit; selects accumulate until the next blanking
      seg_d = seg_decode(shown_i[~pos_q]);
      en_d  = en_q & ~(4'b1000 >> pos_q);
      pos_d = pos_q + 2'd1;
    end else if (phase_inc == lit_end) begin
      seg_d   = SegBlank;
      en_d    = EnablesOff;
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
      seg_q   <= SegBlank;
      en_q    <= EnablesOff;
    end else if (advance_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      seg_q   <= seg_d;
      en_q    <= en_d;
    end
  end

  assign segments_o = seg_q;
  assign enables_o  = en_q;

endmodule

`default_nettype wire

[hdl/pcd_count.sv]
// ----------------------------------------------------------------------------
// pcd_count: product counter with button arming and rollover alarm
// Keeps the count in binary and BCD side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_count
  import pcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire pins_t       pins_i,
  input  wire logic [15:0] alarm_ticks_i,
  output count_t           count_o,
  output logic             alarm_active_o
);

  count_t      cnt_q, cnt_d, c1, c2, c3;
  logic        beam_q, armed_q, armed_d;
  logic [15:0] alarm_q, alarm_d;
  logic        sensor_hit, up_hit, down_hit, clear_hit, roll;

  always_comb begin
    sensor_hit = !pins_i.beam_blocked && beam_q;
    up_hit     = armed_q && !pins_i.up_n;
    down_hit   = armed_q && !pins_i.down_n;
    clear_hit  = armed_q && !pins_i.clear_n;

    // sensor, then up, down and clear in turn
    c1    = sensor_hit ? cnt_inc(cnt_q) : cnt_q;
    c2    = up_hit ? cnt_inc(c1) : c1;
    c3    = down_hit ? cnt_dec(c2) : c2;
    cnt_d = clear_hit ? '0 : c3;

    roll = (sensor_hit && (cnt_q.bin == CountMax)) || (up_hit && (c1.bin == CountMax));

    // re-arm only with all three buttons released
    armed_d = pins_i.up_n && pins_i.down_n && pins_i.clear_n;

    alarm_d = (alarm_q != '0) ? alarm_q - 16'd1 : alarm_q;
    if (roll) begin
      alarm_d = alarm_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      beam_q  <= 1'b0;
      armed_q <= 1'b0;
      alarm_q <= '0;
    end else if (advance_i) begin
      cnt_q   <= cnt_d;
      beam_q  <= pins_i.beam_blocked;
      armed_q <= armed_d;
      alarm_q <= alarm_d;
    end
  end

  assign count_o        = cnt_q;
  assign alarm_active_o = (alarm_q != '0);

endmodule

`default_nettype wire

[hdl/product_counter_display_core.sv]
// ----------------------------------------------------------------------------
// product_counter_display_core: event counter with four-digit display scan
// Input word register, counter and scan state, result word register.
// ----------------------------------------------------------------------------
// Path: a tick word accepted into the input register is offered as a result word
//   once it advances into the state/result register while the result slot is free.
// Throughput: one tick word per cycle while the result channel does not stall.
// Reset: asynchronous, active low; count, alarm and scan state clear, the
//   display goes blank and configuration returns to 4, 4 and 5000 ticks.
`default_nettype none

module product_counter_display_core
  import pcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  pcd_tick_if.sink                tick_i,
  pcd_res_if.source               res_o
);

  // configuration registers
  logic [3:0]  blank_ticks_q, lit_ticks_q;
  logic [15:0] alarm_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_ticks_q <= BlankTicksRst;
      lit_ticks_q   <= LitTicksRst;
      alarm_ticks_q <= AlarmTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLANK_TICKS: blank_ticks_q <= cfg_wdata_i[3:0];
        CFG_LIT_TICKS:   lit_ticks_q   <= cfg_wdata_i[3:0];
        CFG_ALARM_TICKS: alarm_ticks_q <= cfg_wdata_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // input word register and handshake
  logic  in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic  advance, in_load;
  pins_t pins_q;

  // advance a held tick whenever the result slot is free or being taken
  assign advance      = in_valid_q && (!out_valid_q || res_o.ready);
  assign tick_i.ready = !in_valid_q || advance;
  assign in_load      = tick_i.valid && tick_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds until loaded
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      pins_q <= '{beam_blocked: tick_i.beam_blocked, up_n: tick_i.up_n,
                  down_n: tick_i.down_n, clear_n: tick_i.clear_n};
    end
  end

  // state registers double as the result word register: they move only on
  // advance, so a stalled result holds
  count_t    count;
  logic      alarm_active;
  logic [7:0] segments;
  logic [3:0] enables;
  scan_cfg_t scan_cfg;

  assign scan_cfg = '{blank_ticks: blank_ticks_q, lit_ticks: lit_ticks_q};

  pcd_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .pins_i         (pins_q),
    .alarm_ticks_i  (alarm_ticks_q),
    .count_o        (count),
    .alarm_active_o (alarm_active)
  );

  // the scan shows the count as it stood before this tick
  pcd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .cfg_i      (scan_cfg),
    .shown_i    (count.bcd),
    .segments_o (segments),
    .enables_o  (enables)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.segments_n      = segments;
  assign res_o.digit_enables_n = enables;
  assign res_o.alarm_active    = alarm_active;
  assign res_o.count_value     = count.bin;

endmodule

`default_nettype wire
